// ===== sv/bddc_pkg.sv =====
`timescale 1ns / 1ps

package bddc_pkg;

  // counter width of both countdowns
  localparam int TMR_W = 16;
  localparam logic [32:0] TMR_MAX = (33'd1 << TMR_W) - 33'd1;

  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD     = 1'b1;

  localparam logic [1:0] PRESS_SAT = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_DOUBLE  = 2'd3
  } ev_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic stop;
  } tmr_ctrl_t;

  typedef struct packed {
    logic running;
    logic expire;
  } tmr_stat_t;

  // zero loads as one, too-large values clamp to the counter maximum
  function automatic logic [TMR_W-1:0] load_value(input logic [CFG_W-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > TMR_MAX) begin
      w = TMR_MAX;
    end
    if (w == 33'd0) begin
      w = 33'd1;
    end
    return w[TMR_W-1:0];
  endfunction

endpackage

// ===== sv/bddc_timer.sv =====
`timescale 1ns / 1ps

module bddc_timer
  import bddc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_ctrl_t        ctrl,
  input  logic [CFG_W-1:0] load_reg,
  output tmr_stat_t        stat
);

  logic [TMR_W-1:0] cnt_r, cnt_nxt;
  logic             running_r, running_nxt;

  // a running count never sits at zero, so expiry is the step from one
  assign stat.running = running_r;
  assign stat.expire  = running_r && (cnt_r == TMR_W'(1));

  always_comb begin
    cnt_nxt     = cnt_r;
    running_nxt = running_r;
    if (ctrl.load) begin
      cnt_nxt     = load_value(load_reg);
      running_nxt = 1'b1;
    end else if (ctrl.stop || (ctrl.tick && stat.expire)) begin
      cnt_nxt     = '0;
      running_nxt = 1'b0;
    end else if (ctrl.tick && running_r) begin
      cnt_nxt = cnt_r - TMR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      running_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

// ===== sv/button_debounce_double_click.sv =====
`timescale 1ns / 1ps
// result: registered on the clock edge that accepts its item
// throughput: one item per cycle while the input is not stalled, set by a single pass through two countdowns and flags
// input stalls while a result waits; a new item enters in the cycle that result leaves
// reset: synchronous, active low; clears level, timers, press count, hold flag and output valid
// registers return to debounce 1 tick and hold window 300 ticks

module button_debounce_double_click
  import bddc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tick items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_pressed,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_res,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [CFG_W-1:0] debounce_ticks_r;
  logic [CFG_W-1:0] hold_ticks_r;

  // tracking state
  logic       last_level_r, last_level_nxt;
  logic [1:0] press_count_r, press_count_nxt;
  logic       held_r, held_nxt;

  // output register
  logic out_valid_r;
  ev_t  out_event_r;
  ev_t  ev_nxt;

  tmr_ctrl_t db_ctrl, win_ctrl;
  tmr_stat_t db_stat, win_stat;

  logic       in_fire;
  logic       win_exp;
  logic       win_press;
  logic [1:0] pc_a;
  logic       held_a;
  logic       lvl_change;
  logic       settle_press;
  logic       settle_rel;
  logic       dbl;

  // stall only while a finished result is still waiting downstream
  assign in_stall      = out_valid_r && out_stall;
  assign in_fire       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= CFG_W'(1);
      hold_ticks_r     <= CFG_W'(300);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE: debounce_ticks_r <= cfg_wdata;
        REG_HOLD:     hold_ticks_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    // window is handled first: expiry with one press still down means a hold
    win_exp   = win_stat.expire;
    win_press = win_exp && (press_count_r == 2'd1) && in_pressed;
    pc_a      = win_exp ? 2'd0 : press_count_r;
    held_a    = held_r || win_press;

    // any level change restarts the debounce and hides its expiry
    lvl_change   = (in_pressed != last_level_r);
    settle_press = !lvl_change && db_stat.expire && in_pressed;
    settle_rel   = !lvl_change && db_stat.expire && !in_pressed;
    dbl          = settle_rel && (pc_a == 2'd2);

    last_level_nxt  = in_pressed;
    press_count_nxt = pc_a;
    held_nxt        = held_a;
    if (settle_press) begin
      if (pc_a == 2'd0) begin
        held_nxt = 1'b0;
      end
      if (pc_a != PRESS_SAT) begin
        press_count_nxt = pc_a + 2'd1;
      end
    end else if (dbl) begin
      press_count_nxt = 2'd0;
    end

    // double click wins over release
    if (dbl) begin
      ev_nxt = EV_DOUBLE;
    end else if (settle_rel && held_a) begin
      ev_nxt = EV_RELEASE;
    end else if (win_press) begin
      ev_nxt = EV_PRESS;
    end else begin
      ev_nxt = EV_NONE;
    end

    db_ctrl.tick  = in_fire;
    db_ctrl.load  = in_fire && lvl_change;
    db_ctrl.stop  = 1'b0;
    win_ctrl.tick = in_fire;
    win_ctrl.load = in_fire && settle_press && (pc_a == 2'd0);
    win_ctrl.stop = in_fire && dbl;
  end

  bddc_timer u_db_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (db_ctrl),
    .load_reg (debounce_ticks_r),
    .stat     (db_stat)
  );

  bddc_timer u_win_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (win_ctrl),
    .load_reg (hold_ticks_r),
    .stat     (win_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b0;
      press_count_r <= 2'd0;
      held_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        last_level_r  <= last_level_nxt;
        press_count_r <= press_count_nxt;
        held_r        <= held_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event_r <= ev_nxt;
    end
  end

  // a press count is pending exactly while the decision window runs
  a_window_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    win_stat.running == (press_count_r != 2'd0))
    else $error("window state and press count disagree");

  // a reported hold leaves the hold flag armed, unless a new first press clears it
  a_press_arms_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ev_nxt == EV_PRESS && !settle_press) |=> held_r)
    else $error("hold flag not armed after press");

  // a double click closes the window
  a_double_closes_window: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ev_nxt == EV_DOUBLE) |=> (!win_stat.running && press_count_r == 2'd0))
    else $error("window still open after double click");

endmodule

// ===== test/button_debounce_double_click_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_double_click_tb;
  import bddc_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int MAX_REPORTS     = 10;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block ports, all inputs known from time zero
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_pressed = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_event_res;
  logic              cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_DEBOUNCE;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  button_debounce_double_click DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pressed   (in_pressed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_res(out_event_res),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // button model: mirrors the debounce countdown, decision window and flags
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cur_debounce;
  logic [CFG_W-1:0] cur_hold;

  logic             lvl_seen;
  logic [TMR_W-1:0] db_left;
  logic             db_on;
  logic [TMR_W-1:0] win_left;
  logic             win_on;
  logic [1:0]       clicks;
  logic             hold_armed;

  ev_t pending_events[$];

  // zero loads as one, anything wider than the counter clamps to its maximum
  function automatic logic [TMR_W-1:0] timer_reload(input logic [CFG_W-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > TMR_MAX) begin
      w = TMR_MAX;
    end
    if (w == 33'd0) begin
      w = 33'd1;
    end
    return w[TMR_W-1:0];
  endfunction

  function automatic void clear_button_state();
    cur_debounce = CFG_W'(1);
    cur_hold     = CFG_W'(300);
    lvl_seen     = 1'b0;
    db_left      = '0;
    db_on        = 1'b0;
    win_left     = '0;
    win_on       = 1'b0;
    clicks       = 2'd0;
    hold_armed   = 1'b0;
  endfunction

  // one tick of the button: window first, then debounce
  function automatic ev_t predict_event(input logic lvl);
    ev_t ev;
    ev = EV_NONE;
    if (win_on) begin
      if (win_left != 0) begin
        win_left = win_left - 1'b1;
      end
      if (win_left == 0) begin
        win_on = 1'b0;
        // single press still down when the window closes means a hold
        if (clicks == 2'd1 && lvl) begin
          ev = EV_PRESS;
          hold_armed = 1'b1;
        end
        clicks = 2'd0;
      end
    end
    if (lvl != lvl_seen) begin
      // any edge restarts the debounce countdown
      lvl_seen = lvl;
      db_left  = timer_reload(cur_debounce);
      db_on    = 1'b1;
    end else if (db_on) begin
      if (db_left != 0) begin
        db_left = db_left - 1'b1;
      end
      if (db_left == 0) begin
        db_on = 1'b0;
        if (lvl) begin
          if (clicks == 2'd0) begin
            hold_armed = 1'b0;
            win_left   = timer_reload(cur_hold);
            win_on     = 1'b1;
          end
          if (clicks != PRESS_SAT) begin
            clicks = clicks + 1'b1;
          end
        end else begin
          if (hold_armed) begin
            ev = EV_RELEASE;
          end
          // double click wins over release
          if (clicks == 2'd2) begin
            win_on   = 1'b0;
            win_left = '0;
            clicks   = 2'd0;
            ev       = EV_DOUBLE;
          end
        end
      end
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  int items_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  int cfg_settings = 0;
  int ev_tally[4] = '{0, 0, 0, 0};
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  ev_t want_ev;

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout: %0d items sent, %0d results still pending",
             items_sent, pending_events.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void report_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%t: %s", $realtime, what);
    end
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        report_error($sformatf("unexpected result event_res=%0d", out_event_res));
      end else begin
        want_ev = pending_events.pop_front();
        if (out_event_res !== want_ev) begin
          report_error($sformatf("result %0d: event_res expected %s (%0d), got %0d",
                                 results_seen, want_ev.name(), want_ev, out_event_res));
        end else begin
          ev_tally[want_ev]++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one tick item, optionally after idle cycles, and predict its result
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pressed <= lvl;
    do @(posedge clk); while (in_stall);
    pending_events.push_back(predict_event(lvl));
    items_sent++;
  endtask

  task automatic send_run(input logic lvl, input int n);
    for (int i = 0; i < n; i++) begin
      send_tick(lvl);
    end
  endtask

  // both registers, written back to back once the block has drained
  task automatic set_timers(input logic [CFG_W-1:0] db_val, input logic [CFG_W-1:0] hold_val);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DEBOUNCE;
    cfg_wdata <= db_val;
    @(posedge clk);
    cur_debounce = db_val;
    cfg_addr  <= REG_HOLD;
    cfg_wdata <= hold_val;
    @(posedge clk);
    cur_hold = hold_val;
    cfg_we <= 1'b0;
    cfg_settings++;
  endtask

  // one random button gesture sized to the current timers
  task automatic random_gesture();
    int d;
    int h;
    int kind;
    int n;
    d = (cur_debounce == 0) ? 1 : int'(cur_debounce);
    h = (cur_hold == 0) ? 1 : int'(cur_hold);
    // timers too long to settle in a short run: only chatter makes sense
    kind = (d > 64) ? 6 : $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        // single click
        send_run(1'b1, d + 1 + $urandom_range(0, 2));
        send_run(1'b0, d + 1 + $urandom_range(0, 2));
      end
      2, 3: begin
        // double click
        repeat (2) begin
          send_run(1'b1, d + 1 + $urandom_range(0, 2));
          send_run(1'b0, d + 1 + $urandom_range(0, 2));
        end
      end
      4: begin
        // three or four presses in a row
        n = $urandom_range(3, 4);
        repeat (n) begin
          send_run(1'b1, d + 1 + $urandom_range(0, 1));
          send_run(1'b0, d + 1 + $urandom_range(0, 1));
        end
      end
      5: begin
        // long press, near or past the end of a short window, then release, sometimes a chatter and release again
        if (h > 64) begin
          send_run(1'b1, d + 1 + $urandom_range(0, 40));
        end else begin
          send_run(1'b1, d + h + $urandom_range(0, 4));
        end
        send_run(1'b0, d + 1 + $urandom_range(0, 2));
        if ($urandom_range(1) == 1) begin
          send_run(1'b1, $urandom_range(1, d));
          send_run(1'b0, d + 1 + $urandom_range(0, 2));
        end
      end
      6: begin
        // raw chatter
        n = $urandom_range(1, 8);
        repeat (n) begin
          send_tick(1'($urandom_range(1)));
        end
      end
      7: begin
        // click, then a second press whose length is random when the window is short
        send_run(1'b1, d + 1);
        send_run(1'b0, d + 1);
        send_run(1'b1, (h > 64) ? d + 1 : $urandom_range(1, h + 2));
        send_run(1'b0, d + 1 + $urandom_range(0, 2));
      end
      default: begin
        // release of random length, which may let an open window close
        send_run(1'b0, (h > 64) ? $urandom_range(1, 20) : $urandom_range(1, h + d + 4));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of the timers: 1 tick debounce, 300 tick window
  task automatic test_reset_defaults();
    idle_pct  = 0;
    stall_pct = 0;
    send_run(1'b1, 2);
  endtask

  // zero debounce loads as one; double click, hold, release, repeated release
  task automatic test_basic_gestures();
    set_timers(CFG_W'(0), CFG_W'(8));
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 10);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
  endtask

  task automatic test_random_gestures(input logic [CFG_W-1:0] db_val,
                                      input logic [CFG_W-1:0] hold_val,
                                      input int idle, input int stall, input int n_items);
    int stop_at;
    set_timers(db_val, hold_val);
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      random_gesture();
    end
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_backpressure();
    int stop_at;
    set_timers(CFG_W'(2), CFG_W'(10));
    idle_pct  = 0;
    stall_pct = 0;
    hold_reqs++;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) begin
      random_gesture();
    end
  endtask

  // largest register values: nothing settles within a short run
  task automatic test_slow_timers();
    set_timers(CFG_W'('1), CFG_W'('1));
    idle_pct  = 19;
    stall_pct = 19;
    repeat (60) begin
      send_tick(1'($urandom_range(1)));
    end
  endtask

  initial begin
    clear_button_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_basic_gestures();
    test_random_gestures(CFG_W'(2), CFG_W'(12), 0, 0, 350);
    test_random_gestures(CFG_W'(1), CFG_W'(1), 88, 0, 250);
    test_random_gestures(CFG_W'(3), CFG_W'(20), 0, 88, 300);
    test_random_gestures(CFG_W'(0), CFG_W'('1), 19, 19, 250);
    test_output_backpressure();
    test_slow_timers();
    test_random_gestures(CFG_W'(4), CFG_W'(9), 19, 19, 150);

    // drain, then check that no result is still outstanding
    in_valid <= 1'b0;
    while (pending_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
    if (pending_events.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_events.size()));
    end

    $display("%0d tick items over %0d timer settings, %0d results checked",
             items_sent, cfg_settings, results_seen);
    $display("seen: %0d held presses, %0d releases, %0d double clicks, %0d mismatches",
             ev_tally[EV_PRESS], ev_tally[EV_RELEASE], ev_tally[EV_DOUBLE], error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
